/* design/rppd_pkg.sv */
// Package for the RGBW pixel packet deframer: words, queue entry type,
// sizes and header constants. Every design file takes names from it by scope.
package rppd_pkg;

    // Longest packet that is parsed; later bytes are ignored
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int MIN_VALID_BYTES  = 10;
    localparam int FIRST_PIXEL_POS  = 6;

    // Event queue between parser and result stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_VALID   = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    // Configuration register indexes
    localparam logic REG_STRIP_LENGTH = 1'b0;

    // Header characters
    localparam logic [7:0] MAGIC_0 = 8'h57;
    localparam logic [7:0] MAGIC_1 = 8'h4C;
    localparam logic [7:0] MAGIC_2 = 8'h45;
    localparam logic [7:0] MAGIC_3 = 8'h44;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] led_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  white;
        logic [31:0] packets_seen;
        logic [31:0] packets_valid;
        logic [31:0] packets_invalid;
        logic        last;
    } t_out_word;

    // One classified byte: an optional pixel write and an optional packet end
    typedef struct packed {
        logic        has_pixel;
        logic        has_end;
        logic        end_valid;
        logic [15:0] led_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  white;
    } t_event;

    // Expected header byte at a header position
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0:    val = MAGIC_0;
            2'd1:    val = MAGIC_1;
            2'd2:    val = MAGIC_2;
            default: val = MAGIC_3;
        endcase
        return val;
    endfunction

endpackage

/* design/rppd_front.sv */
// Parser front end: accepts packet bytes, tracks header, start index and
// pixel groups, and emits one event per byte that causes results. Uses rppd_pkg.
module rppd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rppd_pkg::t_in_word i_word,
    input  logic [15:0]       i_strip_length,
    output logic              o_push,
    output rppd_pkg::t_event  o_event
);

    logic [rppd_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_hdr_good, n_hdr_good;
    logic [7:0]                 r_start_lo, n_start_lo;
    logic [23:0]                r_partial, n_partial;
    logic [15:0]                r_next_led, n_next_led;
    logic                       r_stopped, n_stopped;
    logic [1:0]                 lane;
    logic                       in_range;

    // Position within a pixel group, counted from the first pixel byte
    assign lane     = r_pos[1:0] - 2'(rppd_pkg::FIRST_PIXEL_POS);
    assign in_range = r_pos < rppd_pkg::POS_W'(rppd_pkg::MAX_PACKET_BYTES);

    // Classify the byte and compute the next per-packet state
    always_comb begin
        n_pos      = r_pos;
        n_hdr_good = r_hdr_good;
        n_start_lo = r_start_lo;
        n_partial  = r_partial;
        n_next_led = r_next_led;
        n_stopped  = r_stopped;
        o_event    = '0;
        o_push     = 1'b0;
        if (i_accept) begin
            if (in_range) begin
                if (r_pos < rppd_pkg::POS_W'(4)) begin
                    if (i_word.data_byte != rppd_pkg::magic_byte(r_pos[1:0])) begin
                        n_hdr_good = 1'b0;
                    end
                end else if (r_pos == rppd_pkg::POS_W'(4)) begin
                    n_start_lo = i_word.data_byte;
                end else if (r_pos == rppd_pkg::POS_W'(5)) begin
                    n_next_led = {i_word.data_byte, r_start_lo};
                end else if (lane != 2'd3) begin
                    case (lane)
                        2'd0:    n_partial[7:0]   = i_word.data_byte;
                        2'd1:    n_partial[15:8]  = i_word.data_byte;
                        default: n_partial[23:16] = i_word.data_byte;
                    endcase
                end else if (r_hdr_good && !r_stopped) begin
                    if (r_next_led >= i_strip_length) begin
                        n_stopped = 1'b1;
                    end else begin
                        o_event.has_pixel = 1'b1;
                        o_event.led_index = r_next_led;
                        o_event.red       = r_partial[7:0];
                        o_event.green     = r_partial[15:8];
                        o_event.blue      = r_partial[23:16];
                        o_event.white     = i_word.data_byte;
                        n_next_led        = r_next_led + 16'd1;
                    end
                end
                n_pos = r_pos + rppd_pkg::POS_W'(1);
            end
            // Close the packet and drop per-packet state
            if (i_word.last_byte) begin
                o_event.has_end   = 1'b1;
                o_event.end_valid = n_hdr_good &&
                    (n_pos >= rppd_pkg::POS_W'(rppd_pkg::MIN_VALID_BYTES));
                n_pos      = '0;
                n_hdr_good = 1'b1;
                n_start_lo = '0;
                n_partial  = '0;
                n_next_led = '0;
                n_stopped  = 1'b0;
            end
            o_push = o_event.has_pixel || o_event.has_end;
        end
    end

    // Hold per-packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hdr_good <= 1'b1;
            r_start_lo <= '0;
            r_partial  <= '0;
            r_next_led <= '0;
            r_stopped  <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_hdr_good <= n_hdr_good;
            r_start_lo <= n_start_lo;
            r_partial  <= n_partial;
            r_next_led <= n_next_led;
            r_stopped  <= n_stopped;
        end
    end

endmodule

/* design/rppd_queue.sv */
// Small event queue between parser and result stage so each side stalls
// on its own. Uses rppd_pkg for the entry type and depth.
module rppd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rppd_pkg::t_event i_event,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output rppd_pkg::t_event o_head
);

    rppd_pkg::t_event                mem [rppd_pkg::QUEUE_DEPTH];
    logic [rppd_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [rppd_pkg::QCNT_W-1:0]     r_count;
    logic                            do_push, do_pop;

    assign o_full  = r_count == rppd_pkg::QCNT_W'(rppd_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_event;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + rppd_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + rppd_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + rppd_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - rppd_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

/* design/rppd_back.sv */
// Result stage: expands queued events into output words, keeps the packet
// counters and holds the output register. Uses rppd_pkg.
module rppd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  rppd_pkg::t_event    i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output rppd_pkg::t_out_word o_word
);

    logic                r_out_valid, n_out_valid;
    rppd_pkg::t_out_word r_out, n_out;
    logic                r_pix_done, n_pix_done;
    logic [31:0]         r_seen, n_seen;
    logic [31:0]         r_valid_cnt, n_valid_cnt;
    logic [31:0]         r_invalid_cnt, n_invalid_cnt;
    logic                slot_free;

    assign slot_free = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;
    assign o_word    = r_out;

    // Pick the next word from the queue head
    always_comb begin
        n_out_valid   = r_out_valid && i_stall;
        n_out         = r_out;
        n_pix_done    = r_pix_done;
        n_seen        = r_seen;
        n_valid_cnt   = r_valid_cnt;
        n_invalid_cnt = r_invalid_cnt;
        o_pop         = 1'b0;
        if (slot_free && !i_empty) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (i_head.has_pixel && !r_pix_done) begin
                n_out.kind      = rppd_pkg::KIND_PIXEL;
                n_out.led_index = i_head.led_index;
                n_out.red       = i_head.red;
                n_out.green     = i_head.green;
                n_out.blue      = i_head.blue;
                n_out.white     = i_head.white;
                n_out.last      = !i_head.has_end;
                // Keep the entry when its packet end is still to come
                if (i_head.has_end) begin
                    n_pix_done = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_seen = r_seen + 32'd1;
                if (i_head.end_valid) begin
                    n_valid_cnt = r_valid_cnt + 32'd1;
                    n_out.kind  = rppd_pkg::KIND_VALID;
                end else begin
                    n_invalid_cnt = r_invalid_cnt + 32'd1;
                    n_out.kind    = rppd_pkg::KIND_INVALID;
                end
                n_out.packets_seen    = n_seen;
                n_out.packets_valid   = n_valid_cnt;
                n_out.packets_invalid = n_invalid_cnt;
                n_out.last            = 1'b1;
                n_pix_done            = 1'b0;
                o_pop                 = 1'b1;
            end
        end
    end

    // Hold output word and counters
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_pix_done    <= 1'b0;
            r_seen        <= '0;
            r_valid_cnt   <= '0;
            r_invalid_cnt <= '0;
        end else begin
            r_out_valid   <= n_out_valid;
            r_pix_done    <= n_pix_done;
            r_seen        <= n_seen;
            r_valid_cnt   <= n_valid_cnt;
            r_invalid_cnt <= n_invalid_cnt;
        end
    end

endmodule

/* design/rgbw_pixel_packet_deframer_unit.sv */
// Top level of the RGBW pixel packet deframer: register port, parser,
// event queue and result stage. Uses rppd_pkg, rppd_front, rppd_queue, rppd_back.
//
// Takes one packet byte per clock while the event queue has room and produces pixel
// writes and a packet-end word with the packet counters. A byte that both completes
// a pixel and ends the packet gives two output words from a single queue entry, and
// the four-entry event queue absorbs that extra word. A result is registered in the
// event queue and then in the output register. The input stalls only when the
// event queue is full. No clearing pass after reset.
module rgbw_pixel_packet_deframer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rppd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rppd_pkg::t_out_word o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0]      r_strip_length;
    logic             accept;
    logic             push, pop, full, empty;
    rppd_pkg::t_event fe_event, head;

    // Register port: write strip length, read it back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rppd_pkg::REG_STRIP_LENGTH) ?
                    {16'd0, r_strip_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_length <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == rppd_pkg::REG_STRIP_LENGTH) begin
            r_strip_length <= pwdata[15:0];
        end
    end

    // Accept a byte whenever the queue has room
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    rppd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_word         (i_in_word),
        .i_strip_length (r_strip_length),
        .o_push         (push),
        .o_event        (fe_event)
    );

    rppd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (fe_event),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    rppd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

/* design/rppd_checker.sv */
// Port-level checks for the RGBW pixel packet deframer, bound to its top
// level. Uses rppd_pkg for result kinds and word types.
module rppd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rppd_pkg::t_out_word o_out_word
);

    // No word right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // Hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // Pixel writes carry no counters
    a_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == rppd_pkg::KIND_PIXEL |->
            o_out_word.packets_seen == 32'd0 && o_out_word.packets_valid == 32'd0 &&
            o_out_word.packets_invalid == 32'd0)
        else $error("pixel write carries counter values");

    // Packet end always closes the byte's results
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind != rppd_pkg::KIND_PIXEL |-> o_out_word.last)
        else $error("packet end word without last flag");

    // Counters stay consistent
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind != rppd_pkg::KIND_PIXEL |->
            o_out_word.packets_seen ==
            o_out_word.packets_valid + o_out_word.packets_invalid)
        else $error("packet counters do not add up");

endmodule

bind rgbw_pixel_packet_deframer_unit rppd_checker u_rppd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
